FILE: rtl/core/kic_pkg.sv
// ----------------------------------------------------------------------------
// kic_pkg: shared types for the keypad integer calculator
// Key codes, controller states and the command/status bundles that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package kic_pkg;

  localparam int CMD_W     = 3;
  localparam int DIGIT_W   = 4;
  localparam int DISP_W    = 32;
  localparam int IN_DATA_W = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_DIGIT  = 3'd0,
    CMD_ADD    = 3'd1,
    CMD_SUB    = 3'd2,
    CMD_MUL    = 3'd3,
    CMD_REM    = 3'd4,
    CMD_DIV    = 3'd5,
    CMD_EQUALS = 3'd6,
    CMD_CLEAR  = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_DECODE = 2'd1,
    ST_ITER   = 2'd2,
    ST_FINISH = 2'd3
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;  // latch the incoming key word
    logic start;    // load the shared multiply/divide unit
    logic step;     // advance the unit by one bit
    logic commit;   // update the calculator state and load the output word
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic needs_iter;  // the key completes a multiply, remainder or divide with a nonzero second operand
    logic iter_done;   // the unit has finished all its bits
    logic out_free;    // the output register can take a word this cycle
  } ctrl_sts_t;

endpackage

FILE: rtl/core/kic_datapath.sv
// ----------------------------------------------------------------------------
// kic_datapath: calculator state, shared multiply/divide unit, output register
// Holds accumulator, second operand and latched operator, and runs a
// one-bit-per-cycle shift-add multiplier or restoring divider on command.
// ----------------------------------------------------------------------------
module kic_datapath #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [kic_pkg::IN_DATA_W-1:0]  in_tdata,
  input  kic_pkg::ctrl_cmd_t             ctl,
  output kic_pkg::ctrl_sts_t             sts,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [kic_pkg::DISP_W-1:0]     out_tdata
);
  import kic_pkg::*;

  localparam int W     = DATA_WIDTH;
  localparam int CNT_W = $clog2(DATA_WIDTH + 1);

  // Captured key word.
  cmd_t               key_r;
  logic [DIGIT_W-1:0] dig_r;

  // Calculator state.
  logic [W-1:0] acc_r, acc_nxt;
  logic [W-1:0] opnd_r, opnd_nxt;
  logic         seen_r, seen_nxt;
  cmd_t         lop_r, lop_nxt;

  // Shared iterative unit: work_a is multiplier or quotient, work_p is
  // product or partial remainder, work_b is multiplicand or divisor.
  logic [W-1:0]     work_a_r, work_b_r, work_p_r;
  logic             mode_div_r;
  logic [CNT_W-1:0] cnt_r;

  logic             out_valid_r;
  logic [DISP_W-1:0] out_data_r;

  logic         na, nb;
  logic [W-1:0] ua, ub, neg_a, neg_b;
  logic [W:0]   shifted, trial;
  logic [W-1:0] digit_val, combined, neg_p, neg_q;
  logic [W-1:0] shown;
  logic         is_op;

  assign na    = acc_r[W-1];
  assign nb    = opnd_r[W-1];
  assign neg_a = -acc_r;
  assign neg_b = -opnd_r;
  assign ua    = na ? neg_a : acc_r;
  assign ub    = nb ? neg_b : opnd_r;

  assign shifted = {work_p_r, work_a_r[W-1]};
  assign trial   = shifted - {1'b0, work_b_r};

  assign is_op = (key_r == CMD_ADD) || (key_r == CMD_SUB) || (key_r == CMD_MUL) ||
                 (key_r == CMD_REM) || (key_r == CMD_DIV);

  assign sts.needs_iter = (is_op || (key_r == CMD_EQUALS)) && (opnd_r != '0) &&
                          ((lop_r == CMD_MUL) || (lop_r == CMD_REM) || (lop_r == CMD_DIV));
  assign sts.iter_done  = (cnt_r == '0);
  assign sts.out_free   = !out_valid_r || out_tready;

  assign neg_p = -work_p_r;
  assign neg_q = -work_a_r;

  always_comb begin
    combined = acc_r;
    if (opnd_r != '0) begin
      case (lop_r)
        CMD_ADD: combined = acc_r + opnd_r;
        CMD_SUB: combined = acc_r - opnd_r;
        CMD_MUL: combined = work_p_r;
        CMD_REM: combined = na ? neg_p : work_p_r;
        CMD_DIV: combined = (na != nb) ? neg_q : work_a_r;
        default: combined = acc_r;
      endcase
    end
  end

  always_comb begin
    // Multiply by ten as shift and add.
    digit_val = seen_r ? opnd_r : acc_r;
    digit_val = (digit_val << 3) + (digit_val << 1) + W'(dig_r);
  end

  always_comb begin
    acc_nxt  = acc_r;
    opnd_nxt = opnd_r;
    seen_nxt = seen_r;
    lop_nxt  = lop_r;
    shown    = '0;
    unique case (key_r)
      CMD_DIGIT: begin
        if (seen_r) opnd_nxt = digit_val;
        else        acc_nxt  = digit_val;
        shown = digit_val;
      end
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_REM, CMD_DIV: begin
        acc_nxt  = combined;
        lop_nxt  = key_r;
        opnd_nxt = '0;
        seen_nxt = 1'b1;
      end
      CMD_EQUALS: begin
        acc_nxt  = combined;
        opnd_nxt = '0;
        seen_nxt = 1'b0;
        shown    = combined;
      end
      CMD_CLEAR: begin
        acc_nxt  = '0;
        opnd_nxt = '0;
        seen_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      key_r <= cmd_t'(in_tdata[CMD_W-1:0]);
      dig_r <= in_tdata[CMD_W +: DIGIT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      opnd_r <= '0;
      seen_r <= 1'b0;
      lop_r  <= CMD_ADD;
    end else if (ctl.commit) begin
      acc_r  <= acc_nxt;
      opnd_r <= opnd_nxt;
      seen_r <= seen_nxt;
      lop_r  <= lop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctl.start) begin
      cnt_r <= CNT_W'(DATA_WIDTH);
    end else if (ctl.step) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      mode_div_r <= (lop_r != CMD_MUL);
      if (lop_r == CMD_MUL) begin
        work_a_r <= opnd_r;
        work_b_r <= acc_r;
        work_p_r <= '0;
      end else begin
        work_a_r <= ua;
        work_b_r <= ub;
        work_p_r <= '0;
      end
    end else if (ctl.step) begin
      if (mode_div_r) begin
        // Restoring step: keep the trial difference when it did not go negative.
        if (!trial[W]) begin
          work_p_r <= trial[W-1:0];
          work_a_r <= {work_a_r[W-2:0], 1'b1};
        end else begin
          work_p_r <= shifted[W-1:0];
          work_a_r <= {work_a_r[W-2:0], 1'b0};
        end
      end else begin
        if (work_a_r[0]) work_p_r <= work_p_r + work_b_r;
        work_b_r <= work_b_r << 1;
        work_a_r <= work_a_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // The display word is the W-bit value sign-extended or truncated to 32 bits.
  always_ff @(posedge clk) begin
    if (ctl.commit) out_data_r <= DISP_W'($signed(shown));
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_commit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |-> (!out_valid_r || out_tready))
    else $error("result committed over an untaken output word");

  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |=> out_tvalid)
    else $error("committed result not presented");

  a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.step |-> (cnt_r != '0))
    else $error("iterative unit stepped past its last bit");

  a_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |=> (cnt_r == CNT_W'(DATA_WIDTH)))
    else $error("iterative unit did not load its bit count");

endmodule

FILE: rtl/core/kic_controller.sv
// ----------------------------------------------------------------------------
// kic_controller: sequencing for the keypad integer calculator
// Accepts one key word at a time, runs the shared unit when the latched
// operator needs it, and commits when the output register has room.
// ----------------------------------------------------------------------------
module kic_controller (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  kic_pkg::ctrl_sts_t sts,
  output kic_pkg::ctrl_cmd_t ctl
);
  import kic_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = ST_DECODE;
      ST_DECODE: state_nxt = sts.needs_iter ? ST_ITER : ST_FINISH;
      ST_ITER:   if (sts.iter_done) state_nxt = ST_FINISH;
      ST_FINISH: if (sts.out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    ctl         = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        ctl.capture = in_tvalid;
      end
      ST_DECODE: ctl.start  = sts.needs_iter;
      ST_ITER:   ctl.step   = !sts.iter_done;
      ST_FINISH: ctl.commit = sts.out_free;
      default: ;
    endcase
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second word accepted while one is in progress");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.capture, ctl.start, ctl.step, ctl.commit}))
    else $error("controller issued overlapping commands");

  a_step_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |=> (state_r == ST_ITER))
    else $error("unit started without entering iteration");

endmodule

FILE: rtl/core/keypad_integer_calculator_top.sv
// ----------------------------------------------------------------------------
// keypad_integer_calculator_top: four-function keypad calculator
// One key word in, one display word out.
// ----------------------------------------------------------------------------
// Each input word carries one key press: a digit, an operator, equals or
// clear. Each accepted word produces exactly one output word holding the
// value to show, sign-extended or truncated to 32 bits.
// One word is processed at a time. Digits, clear, keys that complete an add
// or subtract, and any key whose second operand is zero go from acceptance
// through decode straight to the output register. A key that completes a
// multiply, remainder or divide runs the shared bit-serial multiply/divide
// unit, one bit per cycle, before it commits; that unit sets the sustained
// rate.
// A new word is accepted while the previous result still waits in the output
// register. If the receiver stalls, the next result waits in the datapath
// until the output register is taken, and input is held off meanwhile.
// Reset clears the accumulator, the second operand and the operator flag,
// latches add, and empties the output register.
// ----------------------------------------------------------------------------
module keypad_integer_calculator_top #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [kic_pkg::IN_DATA_W-1:0] in_tdata,   // [2:0] command, [6:3] digit, [7] zero
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [kic_pkg::DISP_W-1:0]    out_tdata   // [31:0] display_value
);
  import kic_pkg::*;

  ctrl_cmd_t ctl;
  ctrl_sts_t sts;

  kic_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  kic_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .ctl        (ctl),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
